// ===== src/csvt_pkg.sv =====
`default_nettype none

package csvt_pkg;

	localparam int MAX_FIELDS_DEF = 64;
	localparam int RES_DEPTH = 4;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_FEND = 2'd1;
	localparam logic [1:0] KIND_LEND = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_UNTERM  = 2'd2;

	localparam logic [6:0] CAP_RESET = 7'd1;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [5:0] field_index;
		logic [1:0] line_status;
		logic [6:0] pad_fields;
		logic       last;
	} res_t;

	function automatic res_t mk_data(input logic [7:0] b, input logic [5:0] idx);
		res_t r;
		r = '0;
		r.kind = KIND_DATA;
		r.data_byte = b;
		r.field_index = idx;
		return r;
	endfunction

	function automatic res_t mk_fend(input logic [5:0] idx);
		res_t r;
		r = '0;
		r.kind = KIND_FEND;
		r.field_index = idx;
		return r;
	endfunction

	function automatic res_t mk_lend(input logic [1:0] status, input logic [6:0] pad);
		res_t r;
		r = '0;
		r.kind = KIND_LEND;
		r.line_status = status;
		r.pad_fields = pad;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/csvt_if.sv =====
`default_nettype none

interface csvt_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] ch;

	modport source (output valid, output cmd, output ch, input ready);
	modport sink (input valid, input cmd, input ch, output ready);
endinterface

interface csvt_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [5:0] field_index;
	logic [1:0] line_status;
	logic [6:0] pad_fields;
	logic       last;

	modport source (output valid, output kind, output data_byte, output field_index,
		output line_status, output pad_fields, output last, input ready);
	modport sink (input valid, input kind, input data_byte, input field_index,
		input line_status, input pad_fields, input last, output ready);
endinterface

interface csvt_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] expected_fields;

	modport source (output valid, output expected_fields, input ready);
	modport sink (input valid, input expected_fields, output ready);
endinterface

`default_nettype wire

// ===== src/csv_line_field_tokenizer.sv =====
`default_nettype none
// the input transaction is registered in the input stage and its results are then written
// into the result queue, whose head drives the output
// throughput: one input transaction per cycle while each yields at most one result and the
// output keeps up; an item with two results (held quote and follower, or field end and line
// end) takes two output transactions, so a run of them is held back behind the 4-entry queue
// reset: parser back to field start, field count zero, expected_fields back to 1, queue empty

module csv_line_field_tokenizer #(
	parameter int MAX_FIELDS = csvt_pkg::MAX_FIELDS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	csvt_in_if.sink     bytes,
	csvt_out_if.source  results,
	csvt_cfg_if.sink    cfg
);

	// fields_done holds up to MAX_FIELDS; cap math is done at least 7 bits wide
	localparam int FW = $clog2(MAX_FIELDS + 1);
	localparam int CW = (FW > 7) ? FW : 7;

	typedef enum logic [4:0] {
		M_START  = 5'b00001,
		M_UNQ    = 5'b00010,
		M_QUOTED = 5'b00100,
		M_QSEEN  = 5'b01000,
		M_SKIP   = 5'b10000
	} mode_t;

	// configuration register, always ready
	logic [6:0] expected_fields_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_fields_q <= csvt_pkg::CAP_RESET;
		end else if (cfg.valid) begin
			expected_fields_q <= cfg.expected_fields;
		end
	end

	// input register stage
	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] ch_s1;
	logic       room2;
	logic       adv_s1;

	assign adv_s1 = valid_s1 && room2;
	assign bytes.ready = !valid_s1 || room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			cmd_s1 <= bytes.cmd;
			ch_s1 <= bytes.ch;
		end
	end

	// parser state, updated when the staged item moves into the result queue
	mode_t         mode_q;
	logic [FW-1:0] fields_done_q;
	logic          after_sep_q;

	mode_t         mode_d;
	logic [FW-1:0] fields_done_d;
	logic          after_sep_d;

	// effective cap: zero acts as one, clamp to MAX_FIELDS
	logic [CW-1:0] cap;
	logic [CW-1:0] fd_ext;
	logic [CW-1:0] fd_inc_ext;
	logic [FW-1:0] fd_inc;
	logic [5:0]    idx;
	mode_t         mode_eff;

	always_comb begin
		if (expected_fields_q == 7'd0) begin
			cap = CW'(1);
		end else if (CW'(expected_fields_q) > CW'(MAX_FIELDS)) begin
			cap = CW'(MAX_FIELDS);
		end else begin
			cap = CW'(expected_fields_q);
		end
	end

	assign fd_ext = CW'(fields_done_q);
	assign fd_inc = fields_done_q + 1'b1;
	assign fd_inc_ext = CW'(fd_inc);
	assign idx = fd_ext[5:0];
	// once the cap is reached the rest of the line is dropped
	assign mode_eff = (mode_q != M_SKIP && fd_ext >= cap) ? M_SKIP : mode_q;

	csvt_pkg::res_t r0;
	csvt_pkg::res_t r1;
	logic [1:0]     n_res;
	logic [1:0]     status;
	logic [CW-1:0]  fd_end;
	logic [CW-1:0]  pad_w;

	always_comb begin
		r0 = '0;
		r1 = '0;
		n_res = 2'd0;
		status = csvt_pkg::ST_OK;
		fd_end = fd_ext;
		pad_w = '0;
		mode_d = mode_eff;
		fields_done_d = fields_done_q;
		after_sep_d = after_sep_q;

		if (!cmd_s1) begin
			case (mode_eff)
				M_START: begin
					after_sep_d = 1'b0;
					if (ch_s1 == csvt_pkg::CH_QUOTE) begin
						mode_d = M_QUOTED;
					end else if (ch_s1 == csvt_pkg::CH_COMMA) begin
						// empty field
						r0 = csvt_pkg::mk_fend(idx);
						n_res = 2'd1;
						fields_done_d = fd_inc;
						after_sep_d = 1'b1;
						mode_d = (fd_inc_ext >= cap) ? M_SKIP : M_START;
					end else begin
						r0 = csvt_pkg::mk_data(ch_s1, idx);
						n_res = 2'd1;
						mode_d = M_UNQ;
					end
				end
				M_UNQ: begin
					if (ch_s1 == csvt_pkg::CH_COMMA) begin
						r0 = csvt_pkg::mk_fend(idx);
						n_res = 2'd1;
						fields_done_d = fd_inc;
						after_sep_d = 1'b1;
						mode_d = (fd_inc_ext >= cap) ? M_SKIP : M_START;
					end else begin
						r0 = csvt_pkg::mk_data(ch_s1, idx);
						n_res = 2'd1;
					end
				end
				M_QUOTED: begin
					if (ch_s1 == csvt_pkg::CH_QUOTE) begin
						mode_d = M_QSEEN;
					end else begin
						r0 = csvt_pkg::mk_data(ch_s1, idx);
						n_res = 2'd1;
					end
				end
				M_QSEEN: begin
					if (ch_s1 == csvt_pkg::CH_COMMA) begin
						// closing quote confirmed
						r0 = csvt_pkg::mk_fend(idx);
						n_res = 2'd1;
						fields_done_d = fd_inc;
						after_sep_d = 1'b1;
						mode_d = (fd_inc_ext >= cap) ? M_SKIP : M_START;
					end else begin
						// doubled quote collapses, a lone quote is kept with its follower
						r0 = csvt_pkg::mk_data(csvt_pkg::CH_QUOTE, idx);
						n_res = 2'd1;
						if (ch_s1 != csvt_pkg::CH_QUOTE) begin
							r1 = csvt_pkg::mk_data(ch_s1, idx);
							n_res = 2'd2;
						end
						mode_d = M_QUOTED;
					end
				end
				default: begin
				end
			endcase
		end else begin
			// end of line: close the open field, then report
			case (mode_eff)
				M_START: begin
					if (after_sep_q) begin
						r0 = csvt_pkg::mk_fend(idx);
						n_res = 2'd1;
						fd_end = fd_inc_ext;
					end else if (fields_done_q == '0) begin
						status = csvt_pkg::ST_EMPTY;
					end
				end
				M_UNQ, M_QSEEN: begin
					r0 = csvt_pkg::mk_fend(idx);
					n_res = 2'd1;
					fd_end = fd_inc_ext;
				end
				M_QUOTED: begin
					status = csvt_pkg::ST_UNTERM;
				end
				default: begin
				end
			endcase
			if (status == csvt_pkg::ST_OK && fd_end < cap) begin
				pad_w = cap - fd_end;
			end
			if (n_res == 2'd1) begin
				r1 = csvt_pkg::mk_lend(status, pad_w[6:0]);
				n_res = 2'd2;
			end else begin
				r0 = csvt_pkg::mk_lend(status, pad_w[6:0]);
				n_res = 2'd1;
			end
			mode_d = M_START;
			fields_done_d = '0;
			after_sep_d = 1'b0;
		end

		if (n_res == 2'd1) begin
			r0.last = 1'b1;
		end else if (n_res == 2'd2) begin
			r1.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_START;
			fields_done_q <= '0;
			after_sep_q <= 1'b0;
		end else if (adv_s1) begin
			mode_q <= mode_d;
			fields_done_q <= fields_done_d;
			after_sep_q <= after_sep_d;
		end
	end

	// result queue, one result per output transaction
	csvt_pkg::res_t head;
	logic           head_valid;

	csvt_res_fifo u_res_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cnt   (adv_s1 ? n_res : 2'd0),
		.push_a     (r0),
		.push_b     (r1),
		.room2      (room2),
		.head_valid (head_valid),
		.head       (head),
		.pop        (results.ready)
	);

	assign results.valid = head_valid;
	assign results.kind = head.kind;
	assign results.data_byte = head.data_byte;
	assign results.field_index = head.field_index;
	assign results.line_status = head.line_status;
	assign results.pad_fields = head.pad_fields;
	assign results.last = head.last;

endmodule

`default_nettype wire

// ===== src/csvt_res_fifo.sv =====
`default_nettype none

module csvt_res_fifo (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [1:0]        push_cnt,
	input  csvt_pkg::res_t         push_a,
	input  csvt_pkg::res_t         push_b,
	output logic                   room2,
	output logic                   head_valid,
	output csvt_pkg::res_t         head,
	input  wire logic              pop
);

	localparam int AW = $clog2(csvt_pkg::RES_DEPTH);
	localparam int CW = $clog2(csvt_pkg::RES_DEPTH + 1);

	csvt_pkg::res_t mem_q [csvt_pkg::RES_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_pop;
	logic [AW-1:0] wr_ptr_p1;

	assign do_pop = pop && (count_q != '0);
	assign wr_ptr_p1 = wr_ptr_q + 1'b1;
	assign room2 = (count_q <= CW'(csvt_pkg::RES_DEPTH - 2));
	assign head_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push_a;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_ptr_p1] <= push_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(push_cnt);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(push_cnt) - CW'(do_pop);
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/tb_csv_line_field_tokenizer.sv =====
`default_nettype none

module tb_csv_line_field_tokenizer;
	import csvt_pkg::*;

	localparam int CLK_PERIOD = 8;
	localparam int RESET_CYCLES = 11;
	localparam int RANDOM_ITEMS = 1800;
	// settling time after the last result, for a byte with no result still inside the block
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES = 250;
	localparam int TIMEOUT = 4_000_000;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_EOL = 1'b1;
	localparam logic ROW_ITEM = 1'b0;
	localparam logic ROW_CFG = 1'b1;

	// parser modes of the prediction
	typedef enum logic [2:0] {
		PM_START,
		PM_UNQ,
		PM_QUOTED,
		PM_QSEEN,
		PM_SKIP
	} parse_mode_t;

	// one line of the directed stimulus: either a register write or an input byte,
	// optionally with its results typed in (n_typed of 0 means use the prediction)
	typedef struct packed {
		logic       op;
		logic [6:0] cap;
		logic       cmd;
		logic [7:0] ch;
		logic [1:0] n_typed;
		res_t       r0;
		res_t       r1;
	} stim_row_t;

	localparam res_t NO_RES = '0;
	localparam res_t LEND_EMPTY = '{KIND_LEND, 8'h00, 6'd0, ST_EMPTY, 7'd0, 1'b1};
	localparam res_t LEND_OK0 = '{KIND_LEND, 8'h00, 6'd0, ST_OK, 7'd0, 1'b1};
	localparam res_t LEND_OK61 = '{KIND_LEND, 8'h00, 6'd0, ST_OK, 7'd61, 1'b1};
	localparam res_t LEND_UNTERM = '{KIND_LEND, 8'h00, 6'd0, ST_UNTERM, 7'd0, 1'b1};
	localparam res_t FEND2_MID = '{KIND_FEND, 8'h00, 6'd2, ST_OK, 7'd0, 1'b0};
	localparam res_t DATA_FF_F1 = '{KIND_DATA, 8'hFF, 6'd1, ST_OK, 7'd0, 1'b1};
	localparam res_t DATA_00_F1 = '{KIND_DATA, 8'h00, 6'd1, ST_OK, 7'd0, 1'b1};

	localparam int N_DIRECTED = 28;
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		// cap 1 straight out of reset: empty line first
		'{ROW_ITEM, 7'd0, CMD_EOL, 8'h00, 2'd1, LEND_EMPTY, NO_RES},
		'{ROW_ITEM, 7'd0, CMD_BYTE, "a", 2'd0, NO_RES, NO_RES},
		// first comma reaches the cap, the rest of the line is dropped
		'{ROW_ITEM, 7'd0, CMD_BYTE, CH_COMMA, 2'd0, NO_RES, NO_RES},
		'{ROW_ITEM, 7'd0, CMD_BYTE, CH_QUOTE, 2'd0, NO_RES, NO_RES},
		'{ROW_ITEM, 7'd0, CMD_EOL, 8'hA5, 2'd1, LEND_OK0, NO_RES},
		// widest cap
		'{ROW_CFG, 7'd64, CMD_BYTE, 8'h00, 2'd0, NO_RES, NO_RES},
		'{ROW_ITEM, 7'd0, CMD_EOL, 8'hFF, 2'd1, LEND_EMPTY, NO_RES},
		// quoted field: doubled quote, lone inner quote, close on comma
		'{ROW_ITEM, 7'd0, CMD_BYTE, CH_QUOTE, 2'd0, NO_RES, NO_RES},
		'{ROW_ITEM, 7'd0, CMD_BYTE, "x", 2'd0, NO_RES, NO_RES},
		'{ROW_ITEM, 7'd0, CMD_BYTE, CH_QUOTE, 2'd0, NO_RES, NO_RES},
		'{ROW_ITEM, 7'd0, CMD_BYTE, CH_QUOTE, 2'd0, NO_RES, NO_RES},
		'{ROW_ITEM, 7'd0, CMD_BYTE, CH_QUOTE, 2'd0, NO_RES, NO_RES},
		'{ROW_ITEM, 7'd0, CMD_BYTE, "y", 2'd0, NO_RES, NO_RES},
		'{ROW_ITEM, 7'd0, CMD_BYTE, CH_QUOTE, 2'd0, NO_RES, NO_RES},
		'{ROW_ITEM, 7'd0, CMD_BYTE, CH_COMMA, 2'd0, NO_RES, NO_RES},
		// unquoted field with byte extremes and a quote kept as data
		'{ROW_ITEM, 7'd0, CMD_BYTE, 8'hFF, 2'd1, DATA_FF_F1, NO_RES},
		'{ROW_ITEM, 7'd0, CMD_BYTE, CH_QUOTE, 2'd0, NO_RES, NO_RES},
		'{ROW_ITEM, 7'd0, CMD_BYTE, 8'h00, 2'd1, DATA_00_F1, NO_RES},
		// trailing comma gives one more empty field
		'{ROW_ITEM, 7'd0, CMD_BYTE, CH_COMMA, 2'd0, NO_RES, NO_RES},
		'{ROW_ITEM, 7'd0, CMD_EOL, 8'h00, 2'd2, FEND2_MID, LEND_OK61},
		// unterminated quote
		'{ROW_ITEM, 7'd0, CMD_BYTE, CH_QUOTE, 2'd0, NO_RES, NO_RES},
		'{ROW_ITEM, 7'd0, CMD_BYTE, "z", 2'd0, NO_RES, NO_RES},
		'{ROW_ITEM, 7'd0, CMD_EOL, 8'h5A, 2'd1, LEND_UNTERM, NO_RES},
		// empty first field, then the cap drops to the number of fields seen mid-line
		'{ROW_ITEM, 7'd0, CMD_BYTE, CH_COMMA, 2'd0, NO_RES, NO_RES},
		'{ROW_ITEM, 7'd0, CMD_BYTE, "b", 2'd0, NO_RES, NO_RES},
		'{ROW_CFG, 7'd1, CMD_BYTE, 8'h00, 2'd0, NO_RES, NO_RES},
		'{ROW_ITEM, 7'd0, CMD_BYTE, "c", 2'd0, NO_RES, NO_RES},
		'{ROW_ITEM, 7'd0, CMD_EOL, 8'h00, 2'd1, LEND_OK0, NO_RES}
	};

	// caps for the first random phases: zero and values above the maximum included
	localparam logic [6:0] CAP_PLAN [8] = '{7'd0, 7'd127, 7'd2, 7'd64, 7'd1, 7'd5, 7'd65, 7'd3};

	logic clk;
	logic arst_n;

	csvt_in_if bytes_if();
	csvt_out_if res_if();
	csvt_cfg_if cfg_if();

	csv_line_field_tokenizer DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (bytes_if),
		.results (res_if),
		.cfg     (cfg_if)
	);

	// tokenizer state as the testbench sees it
	parse_mode_t pmode;
	logic [6:0]  fields_seen;
	logic        after_comma;
	logic [6:0]  cap_reg;

	res_t        step_tokens[$];   // results of the byte just accepted
	res_t        pending_tokens[$];
	logic [8:0]  line_items[$];    // {cmd, ch} of the line being built

	int          sent_items;
	int          error_count;
	int          burst_left;

	always #(CLK_PERIOD / 2) clk = ~clk;

	//------------------------------------------------------------------
	// prediction
	//------------------------------------------------------------------

	// zero acts as one, anything above the maximum acts as the maximum
	function automatic logic [6:0] eff_cap(input logic [6:0] v);
		if (v == 7'd0)
			return 7'd1;
		if (v > 7'(MAX_FIELDS_DEF))
			return 7'(MAX_FIELDS_DEF);
		return v;
	endfunction

	function automatic void push_token(input logic [1:0] kind, input logic [7:0] b,
		input logic [5:0] idx, input logic [1:0] st, input logic [6:0] pad);
		res_t r;
		r = '0;
		r.kind = kind;
		r.data_byte = b;
		r.field_index = idx;
		r.line_status = st;
		r.pad_fields = pad;
		step_tokens.push_back(r);
	endfunction

	function automatic void close_field(input logic [6:0] cap);
		push_token(KIND_FEND, 8'h00, fields_seen[5:0], ST_OK, 7'd0);
		fields_seen++;
		after_comma = 1'b1;
		pmode = (fields_seen >= cap) ? PM_SKIP : PM_START;
	endfunction

	function automatic void tokenize(input logic cmd, input logic [7:0] ch);
		logic [6:0] cap;
		logic [1:0] st;
		logic [6:0] pad;
		step_tokens.delete();
		cap = eff_cap(cap_reg);
		// cap reached, possibly by a register write mid-line
		if (pmode != PM_SKIP && fields_seen >= cap)
			pmode = PM_SKIP;
		if (cmd == CMD_BYTE) begin
			case (pmode)
				PM_START: begin
					after_comma = 1'b0;
					if (ch == CH_QUOTE)
						pmode = PM_QUOTED;
					else if (ch == CH_COMMA)
						close_field(cap);
					else begin
						push_token(KIND_DATA, ch, fields_seen[5:0], ST_OK, 7'd0);
						pmode = PM_UNQ;
					end
				end
				PM_UNQ: begin
					if (ch == CH_COMMA)
						close_field(cap);
					else
						push_token(KIND_DATA, ch, fields_seen[5:0], ST_OK, 7'd0);
				end
				PM_QUOTED: begin
					if (ch == CH_QUOTE)
						pmode = PM_QSEEN;
					else
						push_token(KIND_DATA, ch, fields_seen[5:0], ST_OK, 7'd0);
				end
				PM_QSEEN: begin
					// a comma confirms the held quote as closing; otherwise it was doubled or lone
					if (ch == CH_COMMA)
						close_field(cap);
					else begin
						push_token(KIND_DATA, CH_QUOTE, fields_seen[5:0], ST_OK, 7'd0);
						if (ch != CH_QUOTE)
							push_token(KIND_DATA, ch, fields_seen[5:0], ST_OK, 7'd0);
						pmode = PM_QUOTED;
					end
				end
				default: ;
			endcase
		end else begin
			st = ST_OK;
			case (pmode)
				PM_START: begin
					if (after_comma) begin
						push_token(KIND_FEND, 8'h00, fields_seen[5:0], ST_OK, 7'd0);
						fields_seen++;
					end else if (fields_seen == 7'd0) begin
						st = ST_EMPTY;
					end
				end
				PM_UNQ, PM_QSEEN: begin
					push_token(KIND_FEND, 8'h00, fields_seen[5:0], ST_OK, 7'd0);
					fields_seen++;
				end
				PM_QUOTED: st = ST_UNTERM;
				default: ;
			endcase
			pad = (st == ST_OK && fields_seen < cap) ? cap - fields_seen : 7'd0;
			push_token(KIND_LEND, 8'h00, 6'd0, st, pad);
			pmode = PM_START;
			fields_seen = 7'd0;
			after_comma = 1'b0;
		end
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].last = 1'b1;
	endfunction

	//------------------------------------------------------------------
	// random line content
	//------------------------------------------------------------------

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 1) == 1)
			return 8'h61 + 8'($urandom_range(0, 25));
		return 8'($urandom_range(0, 255));
	endfunction

	// mostly well-formed lines with random content, some noise and broken lines
	function automatic void build_line(input int cap_eff);
		int style;
		int n_fields;
		int hi;
		int ending;
		logic [7:0] b;
		line_items.delete();
		style = $urandom_range(0, 99);
		if (style < 6) begin
			// empty line, just the end of line below
		end else if (style < 18) begin
			// noise rich in separators and quotes
			repeat ($urandom_range(1, 12)) begin
				case ($urandom_range(0, 2))
					0: b = CH_COMMA;
					1: b = CH_QUOTE;
					default: b = pick_byte();
				endcase
				line_items.push_back({CMD_BYTE, b});
			end
		end else begin
			hi = (cap_eff + 2 < 8) ? cap_eff + 2 : 8;
			// now and then a line around the cap, otherwise short lines
			if (cap_eff > 6 && $urandom_range(0, 7) == 0)
				n_fields = $urandom_range(cap_eff - 2, cap_eff + 2);
			else
				n_fields = $urandom_range(1, hi);
			for (int f = 0; f < n_fields; f++) begin
				if (f > 0)
					line_items.push_back({CMD_BYTE, CH_COMMA});
				case ($urandom_range(0, 3))
					0: ;  // empty field
					1: begin
						// unquoted, inner quotes kept as data
						repeat ($urandom_range(1, 4)) begin
							b = pick_byte();
							if (b == CH_COMMA)
								b = CH_QUOTE;
							line_items.push_back({CMD_BYTE, b});
						end
					end
					default: begin
						line_items.push_back({CMD_BYTE, CH_QUOTE});
						repeat ($urandom_range(0, 4)) begin
							case ($urandom_range(0, 9))
								0: begin
									// doubled quote
									line_items.push_back({CMD_BYTE, CH_QUOTE});
									line_items.push_back({CMD_BYTE, CH_QUOTE});
								end
								1: begin
									// lone inner quote
									line_items.push_back({CMD_BYTE, CH_QUOTE});
									line_items.push_back({CMD_BYTE, 8'h61 + 8'($urandom_range(0, 25))});
								end
								2: line_items.push_back({CMD_BYTE, CH_COMMA});
								default: begin
									b = pick_byte();
									if (b == CH_QUOTE)
										b = 8'h51;
									line_items.push_back({CMD_BYTE, b});
								end
							endcase
						end
						line_items.push_back({CMD_BYTE, CH_QUOTE});
					end
				endcase
			end
			ending = $urandom_range(0, 99);
			if (ending < 10) begin
				// trailing comma
				line_items.push_back({CMD_BYTE, CH_COMMA});
			end else if (ending < 18) begin
				// last field opens a quote that never closes
				line_items.push_back({CMD_BYTE, CH_COMMA});
				line_items.push_back({CMD_BYTE, CH_QUOTE});
				repeat ($urandom_range(0, 3))
					line_items.push_back({CMD_BYTE, pick_byte() & 8'hDF | 8'h40});
			end
		end
		line_items.push_back({CMD_EOL, 8'($urandom_range(0, 255))});
	endfunction

	//------------------------------------------------------------------
	// input side: bursts of transactions with random gaps
	//------------------------------------------------------------------

	task automatic send_item(input logic cmd, input logic [7:0] ch, input logic [1:0] n_typed,
		input res_t r0, input res_t r1);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 24);
			if (gap != 0) begin
				bytes_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		bytes_if.valid <= 1'b1;
		bytes_if.cmd <= cmd;
		bytes_if.ch <= ch;
		do
			@(posedge clk);
		while (!bytes_if.ready);
		burst_left--;
		// transaction accepted at this edge: predict what it causes
		tokenize(cmd, ch);
		sent_items++;
		if (n_typed == 2'd0) begin
			foreach (step_tokens[k])
				pending_tokens.push_back(step_tokens[k]);
		end else begin
			pending_tokens.push_back(r0);
			if (n_typed == 2'd2)
				pending_tokens.push_back(r1);
		end
	endtask

	task automatic wait_tokens_drained();
		do
			@(posedge clk);
		while (pending_tokens.size() != 0);
		// a trailing byte with no result may still be inside the block
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register writes only once the block has gone quiet
	task automatic set_cap(input logic [6:0] v);
		bytes_if.valid <= 1'b0;
		burst_left = 0;
		wait_tokens_drained();
		cfg_if.valid <= 1'b1;
		cfg_if.expected_fields <= v;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		cap_reg = v;
	endtask

	//------------------------------------------------------------------
	// output side: stall patterns plus two long hold-offs for back-pressure
	//------------------------------------------------------------------

	int rx_taken;
	int rx_hold_left;
	int rx_style;
	int rx_style_left;
	int rx_cycle;

	always @(posedge clk) begin
		rx_cycle++;
		if (arst_n && res_if.valid && res_if.ready) begin
			rx_taken++;
			// hold off long enough for the queue inside to fill and stall the input
			if (rx_taken == 300 || rx_taken == 1100)
				rx_hold_left = HOLD_CYCLES;
		end
		if (rx_style_left == 0) begin
			rx_style = $urandom_range(0, 3);
			rx_style_left = $urandom_range(50, 300);
		end else begin
			rx_style_left--;
		end
		if (rx_hold_left != 0) begin
			rx_hold_left--;
			res_if.ready <= 1'b0;
		end else begin
			case (rx_style)
				0: res_if.ready <= 1'b1;
				1: res_if.ready <= 1'($urandom_range(0, 1));
				2: res_if.ready <= ($urandom_range(0, 9) != 0);
				default: res_if.ready <= (rx_cycle % 3 == 0);
			endcase
		end
	end

	//------------------------------------------------------------------
	// result checking against the oldest expectation
	//------------------------------------------------------------------

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_tokens.size() == 0) begin
				$error("result transaction with nothing expected: kind %0d field %0d",
					res_if.kind, res_if.field_index);
				error_count++;
			end else begin
				want = pending_tokens.pop_front();
				check_field("kind", 8'(want.kind), 8'(res_if.kind));
				check_field("data_byte", want.data_byte, res_if.data_byte);
				check_field("field_index", 8'(want.field_index), 8'(res_if.field_index));
				check_field("line_status", 8'(want.line_status), 8'(res_if.line_status));
				check_field("pad_fields", 8'(want.pad_fields), 8'(res_if.pad_fields));
				check_field("last", 8'(want.last), 8'(res_if.last));
			end
		end
	end

	//------------------------------------------------------------------
	// stimulus
	//------------------------------------------------------------------

	initial begin
		int phase;
		int phase_goal;
		int n_send;
		bit end_phase;
		logic [6:0] cap_v;

		clk = 1'b0;
		arst_n = 1'b0;
		bytes_if.valid = 1'b0;
		bytes_if.cmd = CMD_BYTE;
		bytes_if.ch = 8'h00;
		cfg_if.valid = 1'b0;
		cfg_if.expected_fields = CAP_RESET;
		res_if.ready = 1'b0;

		pmode = PM_START;
		fields_seen = 7'd0;
		after_comma = 1'b0;
		cap_reg = CAP_RESET;
		sent_items = 0;
		error_count = 0;
		burst_left = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		for (int i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED[i].op == ROW_CFG)
				set_cap(DIRECTED[i].cap);
			else
				send_item(DIRECTED[i].cmd, DIRECTED[i].ch, DIRECTED[i].n_typed,
					DIRECTED[i].r0, DIRECTED[i].r1);
		end

		// random phases, each under its own cap; some end mid-line so the
		// next cap applies to a line already under way
		sent_items = 0;
		phase = 0;
		while (sent_items < RANDOM_ITEMS) begin
			if (phase < 8)
				cap_v = CAP_PLAN[phase];
			else if ($urandom_range(0, 4) == 0)
				cap_v = 7'($urandom_range(0, 127));
			else
				cap_v = 7'($urandom_range(1, 12));
			phase++;
			set_cap(cap_v);
			phase_goal = sent_items + $urandom_range(100, 200);
			end_phase = 1'b0;
			while (sent_items < phase_goal && !end_phase) begin
				build_line(int'(eff_cap(cap_reg)));
				n_send = line_items.size();
				if (n_send > 1 && $urandom_range(0, 39) == 0) begin
					n_send = $urandom_range(1, n_send - 1);
					end_phase = 1'b1;
				end
				for (int k = 0; k < n_send; k++)
					send_item(line_items[k][8], line_items[k][7:0], 2'd0, NO_RES, NO_RES);
			end
		end

		bytes_if.valid <= 1'b0;
		wait_tokens_drained();

		if (error_count == 0)
			$display("** csv_line_field_tokenizer: PASSED **");
		else
			$display("** csv_line_field_tokenizer: FAILED **");
		$finish;
	end

	// watchdog
	initial begin
		#TIMEOUT;
		$display("** csv_line_field_tokenizer: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
src/csvt_pkg.sv
src/csvt_if.sv
src/csvt_res_fifo.sv
src/csv_line_field_tokenizer.sv
tb/sv/tb_csv_line_field_tokenizer.sv
